/* rtl/plde_pkg.sv */
// Package for the delta varbyte posting list encoder.
// Holds widths, constants and the item and result types; depends on nothing.
`default_nettype none

package plde_pkg;

  localparam int OFFSET_BITS    = 11;
  localparam int BLOCK_BITS     = 32;
  localparam int KEY_BITS       = BLOCK_BITS + OFFSET_BITS;
  localparam int MAX_CODE_BYTES = 7;
  localparam int GROUP_BITS     = 7;
  localparam int CODE_BITS      = 56;
  localparam int LEN_BITS       = 3;
  localparam int BUDGET_BITS    = 16;
  localparam int COUNT_BITS     = 17;

  localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 16'd256;
  localparam logic [7:0]             GROUP_MASK   = 8'h7F;
  localparam logic [7:0]             CONT_FLAG    = 8'h80;

  typedef struct packed {
    logic [BLOCK_BITS-1:0]  block_number;
    logic [OFFSET_BITS-1:0] row_offset;
    logic                   first_item;
    logic                   last_item;
  } item_t;

  typedef struct packed {
    logic                   accepted;
    logic [CODE_BITS-1:0]   code_bytes;
    logic [LEN_BITS-1:0]    code_length;
    logic                   order_error;
    logic                   list_full;
    logic [BUDGET_BITS-1:0] bytes_used;
    logic [COUNT_BITS-1:0]  items_packed;
    logic                   pad_needed;
  } result_t;

endpackage

`default_nettype wire

/* rtl/plde_varbyte.sv */
// Parallel little-endian varbyte split of a key delta into 7-bit groups.
// Depends on plde_pkg.
`default_nettype none

module plde_varbyte (
  input  wire logic [plde_pkg::KEY_BITS-1:0]  value,
  output logic      [plde_pkg::CODE_BITS-1:0] code,
  output logic      [plde_pkg::LEN_BITS-1:0]  length
);

  logic [plde_pkg::MAX_CODE_BYTES-2:0] more;
  logic [plde_pkg::LEN_BITS-1:0]       count;

  always_comb begin
    logic [7:0] grp;
    code  = '0;
    count = plde_pkg::LEN_BITS'(1);
    for (int i = 0; i < plde_pkg::MAX_CODE_BYTES - 1; i++) begin
      more[i] = (value >> (plde_pkg::GROUP_BITS * (i + 1))) != '0;
    end
    for (int i = 0; i < plde_pkg::MAX_CODE_BYTES - 1; i++) begin
      grp = 8'(value >> (plde_pkg::GROUP_BITS * i));
      if (more[i]) begin
        code[8*i +: 8] = plde_pkg::CONT_FLAG | (grp & plde_pkg::GROUP_MASK);
        count = count + plde_pkg::LEN_BITS'(1);
      end else if (i == 0 || more[(i > 0) ? i - 1 : 0]) begin
        code[8*i +: 8] = grp & plde_pkg::GROUP_MASK;
      end
    end
    if (more[plde_pkg::MAX_CODE_BYTES-2]) begin
      code[8*(plde_pkg::MAX_CODE_BYTES-1) +: 8] =
        8'(value >> (plde_pkg::GROUP_BITS * (plde_pkg::MAX_CODE_BYTES - 1)));
    end
    length = count;
  end

endmodule

`default_nettype wire

/* rtl/plde_list_ctrl.sv */
// List state and per-item decision: order check, budget fit and counters.
// Depends on plde_pkg and plde_varbyte.
`default_nettype none

module plde_list_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             advance,
  input  wire plde_pkg::item_t                  item,
  input  wire logic [plde_pkg::BUDGET_BITS-1:0] budget,
  output plde_pkg::result_t                     result
);

  logic [plde_pkg::KEY_BITS-1:0]    previous_key, previous_key_next;
  logic [plde_pkg::BUDGET_BITS-1:0] used_bytes, used_bytes_next;
  logic [plde_pkg::COUNT_BITS-1:0]  packed_count, packed_count_next;
  logic                             full_flag, full_flag_next;

  logic [plde_pkg::KEY_BITS-1:0]    key;
  logic [plde_pkg::KEY_BITS:0]      diff;
  logic                             not_greater;
  logic [plde_pkg::CODE_BITS-1:0]   code;
  logic [plde_pkg::LEN_BITS-1:0]    len;
  logic [plde_pkg::BUDGET_BITS:0]   sum;
  logic                             fits;

  assign key         = {item.block_number, item.row_offset[plde_pkg::OFFSET_BITS-1:0]};
  assign diff        = {1'b0, key} - {1'b0, previous_key};
  assign not_greater = diff[plde_pkg::KEY_BITS] || (diff[plde_pkg::KEY_BITS-1:0] == '0);
  assign sum         = {1'b0, used_bytes} + (plde_pkg::BUDGET_BITS + 1)'(len);
  assign fits        = sum <= {1'b0, budget};

  plde_varbyte u_varbyte (
    .value  (diff[plde_pkg::KEY_BITS-1:0]),
    .code   (code),
    .length (len)
  );

  always_comb begin
    previous_key_next  = previous_key;
    used_bytes_next    = used_bytes;
    packed_count_next  = packed_count;
    full_flag_next     = full_flag;
    result             = '0;
    if (item.first_item) begin
      previous_key_next  = key;
      used_bytes_next    = '0;
      packed_count_next  = plde_pkg::COUNT_BITS'(1);
      full_flag_next     = 1'b0;
      result.accepted    = 1'b1;
    end else if (packed_count != '0) begin
      if (not_greater) begin
        result.order_error = 1'b1;
      end else if (!full_flag) begin
        if (!fits) begin
          full_flag_next = 1'b1;
        end else begin
          used_bytes_next    = sum[plde_pkg::BUDGET_BITS-1:0];
          if (packed_count != '1) begin
            packed_count_next = packed_count + plde_pkg::COUNT_BITS'(1);
          end
          previous_key_next  = key;
          result.accepted    = 1'b1;
          result.code_bytes  = code;
          result.code_length = len;
        end
      end
    end
    result.list_full    = full_flag_next;
    result.bytes_used   = used_bytes_next;
    result.items_packed = packed_count_next;
    result.pad_needed   = item.last_item & used_bytes_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_key <= '0;
      used_bytes   <= '0;
      packed_count <= '0;
      full_flag    <= 1'b0;
    end else if (advance) begin
      previous_key <= previous_key_next;
      used_bytes   <= used_bytes_next;
      packed_count <= packed_count_next;
      full_flag    <= full_flag_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/posting_list_delta_varbyte_encoder_core.sv */
// Top level of the delta varbyte posting list encoder: input register,
// result register, budget register and handshakes.
// Depends on plde_pkg and plde_list_ctrl.
//
// Usage: row pointers enter on the input channel (in_valid / in_stall) with
// first_item opening a list and last_item marking its end. Each transaction
// yields exactly one result on the output channel (out_valid / out_stall).
// The byte budget is written through cfg_valid / cfg_ready; cfg_ready is
// always high and a write takes effect on the next item.
// Path: an accepted item waits in the input register, and its result is
// written to the result register once the output channel can take it.
// Throughput: one item per cycle while the receiver does not stall. The list
// state loop (key subtract, varbyte length and budget compare) is combinational.
// When the receiver stalls, the result holds, the input register still
// takes one more item, and in_stall rises only once both registers are full.
// Reset clears the list state, empties both registers and sets the budget
// to 256 bytes.
`default_nettype none

module posting_list_delta_varbyte_encoder_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [plde_pkg::BLOCK_BITS-1:0]       block_number,
  input  wire logic [plde_pkg::OFFSET_BITS-1:0]      row_offset,
  input  wire logic                                  first_item,
  input  wire logic                                  last_item,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       accepted,
  output logic      [plde_pkg::CODE_BITS-1:0]        code_bytes,
  output logic      [plde_pkg::LEN_BITS-1:0]         code_length,
  output logic                                       order_error,
  output logic                                       list_full,
  output logic      [plde_pkg::BUDGET_BITS-1:0]      bytes_used,
  output logic      [plde_pkg::COUNT_BITS-1:0]       items_packed,
  output logic                                       pad_needed,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [plde_pkg::BUDGET_BITS-1:0]      byte_budget
);

  plde_pkg::item_t                  item_reg;
  logic                             in_full;
  plde_pkg::result_t                result_reg;
  plde_pkg::result_t                result_comb;
  logic                             out_full;
  logic [plde_pkg::BUDGET_BITS-1:0] budget;
  logic                             advance;
  logic                             take;

  assign advance   = in_full && (!out_full || !out_stall);
  assign in_stall  = in_full && out_full && out_stall;
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  plde_list_ctrl u_list_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_reg),
    .budget  (budget),
    .result  (result_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
      budget   <= plde_pkg::BUDGET_RESET;
    end else begin
      if (take) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_full <= 1'b1;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        budget <= byte_budget;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_reg.block_number <= block_number;
      item_reg.row_offset   <= row_offset;
      item_reg.first_item   <= first_item;
      item_reg.last_item    <= last_item;
    end
    if (advance) begin
      result_reg <= result_comb;
    end
  end

  assign out_valid    = out_full;
  assign accepted     = result_reg.accepted;
  assign code_bytes   = result_reg.code_bytes;
  assign code_length  = result_reg.code_length;
  assign order_error  = result_reg.order_error;
  assign list_full    = result_reg.list_full;
  assign bytes_used   = result_reg.bytes_used;
  assign items_packed = result_reg.items_packed;
  assign pad_needed   = result_reg.pad_needed;

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while the result register could drain.");

  a_header_has_no_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted && code_length == '0) |-> (items_packed == 17'd1))
    else $error("Accepted item without code is not a list header.");

  a_rejected_is_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (code_length == '0 && code_bytes == '0))
    else $error("Rejected item carries code bytes.");

  a_order_error_rejects: assert property (@(posedge clk) disable iff (rst)
    (out_valid && order_error) |-> !accepted)
    else $error("Out-of-order item was packed.");

endmodule

`default_nettype wire
